### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("check failed");

// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("check failed");

`endif

### rtl/core/sfvm_pkg.sv
// Package with the opcodes, state encoding and default sizes of the execute unit.
`timescale 1ns / 1ps
`default_nettype none
package sfvm_pkg;
    localparam int DefRegCount  = 64;
    localparam int DefProgDepth = 1024;

    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_SUB  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_COPY = 5'd5;
    localparam logic [4:0] OP_LOAD = 5'd6;
    localparam logic [4:0] OP_JMP  = 5'd7;
    localparam logic [4:0] OP_JMF  = 5'd8;
    localparam logic [4:0] OP_LT   = 5'd9;
    localparam logic [4:0] OP_GT   = 5'd10;
    localparam logic [4:0] OP_EQ   = 5'd11;
    localparam logic [4:0] OP_CALL = 5'd12;
    localparam logic [4:0] OP_RET  = 5'd13;
    localparam logic [4:0] OP_HALT = 5'd14;
    localparam logic [4:0] OP_POP  = 5'd15;
    localparam logic [4:0] OP_PUSH = 5'd16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ1,
        ST_READ2,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage
`default_nettype wire

### rtl/core/sfvm_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module sfvm_divider
    import sfvm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output div_ctl_t         status,
    output logic             done,
    output logic      [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        done      = 1'b0;
        if (start) begin
            quo_next  = dividend[31] ? 32'(-dividend) : dividend;
            dvs_next  = divisor[31] ? 32'(-divisor) : divisor;
            rem_next  = '0;
            cnt_next  = 6'd32;
            neg_next  = dividend[31] ^ divisor[31];
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign quotient = neg_reg ? 32'(-quo_next) : quo_next;
    assign status   = '{start: start, busy: busy_reg};
endmodule
`default_nettype wire

### rtl/core/sfvm_regfile.sv
// Register file memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sfvm_regfile #(
    parameter int REG_COUNT = 64,
    localparam int AW = $clog2(REG_COUNT)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);
    logic [31:0] mem [REG_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/stack_frame_vm_execute_unit.sv
// Top level of the frame-based virtual machine execute unit.
//
// One instruction is taken per input beat on the s_ channel (kind in tuser,
// field_a, field_b and field_c in tdata) and exactly one result beat leaves
// on the m_ channel. The unit works on one instruction at a time.
// Each instruction makes two reads of the register file memory, which has
// one read port with a registered output, then executes and gives its
// result; a divide by a non-zero divisor also runs the bit-serial divider.
// The unit takes no new beat until the result of the last one has been
// accepted; it then returns to the idle state, where s_axis_tready is high.
// After reset a clearing pass writes zero to every register, one entry per
// cycle, while s_axis_tready stays low. The program counter, frame base
// and stop flag clear at once.
// The result sits in an output register; while the receiver stalls the unit
// holds it and accepts no new instruction. Once halted, every instruction
// repeats the program counter and frame base with halted set and no write.
`timescale 1ns / 1ps
`default_nettype none
module stack_frame_vm_execute_unit
    import sfvm_pkg::*;
#(
    parameter int REG_COUNT  = DefRegCount,
    parameter int PROG_DEPTH = DefProgDepth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // field_a [9:0], field_b [41:10], field_c [73:42], zero fill [79:74]
    input  wire logic [79:0] s_axis_tdata,
    // kind [4:0]
    input  wire logic [4:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // next_pc [9:0], halted [10], wrote [11], write_index [17:12],
    // write_value [49:18], frame_base_out [55:50], div_error [56], zero [63:57]
    output logic [63:0]      m_axis_tdata
);
    localparam int AW = $clog2(REG_COUNT);
    localparam int PW = $clog2(PROG_DEPTH);

    state_t state_reg, state_next;

    logic [4:0]    kind_reg, kind_next;
    logic [9:0]    fa_reg, fa_next;
    logic [31:0]   fb_reg, fb_next;
    logic [31:0]   fc_reg, fc_next;
    logic [31:0]   x_reg, x_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [AW-1:0] fbase_reg, fbase_next;
    logic          stop_reg, stop_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [63:0]   out_reg, out_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    logic          div_start, div_done;
    logic [31:0]   div_q;
    div_ctl_t      div_stat;

    logic [PW-1:0] seq_pc;
    logic [AW-1:0] idx_a, idx_b, idx_c, abs_a;
    logic          ex_wrote, ex_derr;
    logic [AW-1:0] ex_widx;
    logic [31:0]   ex_wval;
    logic [PW-1:0] ex_pc;
    logic          cmp_r;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    assign seq_pc = pc_reg + PW'(1);
    assign idx_a  = fbase_reg + fa_reg[AW-1:0];
    assign idx_b  = fbase_reg + fb_reg[AW-1:0];
    assign idx_c  = fbase_reg + fc_reg[AW-1:0];
    assign abs_a  = fa_reg[AW-1:0];

    sfvm_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    sfvm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(x_reg), .divisor(rdata), .status(div_stat),
        .done(div_done), .quotient(div_q)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(REG_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_READ1;
            ST_READ1: state_next = ST_READ2;
            ST_READ2: state_next = ST_EXEC;
            ST_EXEC:  begin
                if (!stop_reg && kind_reg == OP_DIV && rdata != '0) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Execute logic: the second operand (or tested/return register) is rdata.
    always_comb begin
        ex_wrote = 1'b0;
        ex_derr  = 1'b0;
        ex_widx  = idx_a;
        ex_wval  = '0;
        ex_pc    = seq_pc;
        cmp_r    = 1'b0;
        case (kind_reg) inside
            OP_ADD:  begin ex_wrote = 1'b1; ex_wval = x_reg + rdata; end
            OP_MUL:  begin ex_wrote = 1'b1; ex_wval = 32'(x_reg * rdata); end
            OP_SUB:  begin ex_wrote = 1'b1; ex_wval = x_reg - rdata; end
            OP_DIV:  begin
                ex_wrote = 1'b1;
                ex_derr  = (rdata == '0);
                ex_wval  = '0;
            end
            OP_COPY: begin ex_wrote = 1'b1; ex_wval = x_reg; end
            OP_LOAD: begin ex_wrote = 1'b1; ex_wval = fb_reg; end
            OP_JMP:  ex_pc = PW'(fa_reg);
            OP_JMF:  if (rdata == '0) ex_pc = fb_reg[PW-1:0];
            OP_LT, OP_GT, OP_EQ: begin
                if (kind_reg == OP_LT) cmp_r = $signed(fb_reg) < $signed(fc_reg);
                else if (kind_reg == OP_GT) cmp_r = $signed(fb_reg) > $signed(fc_reg);
                else cmp_r = (fb_reg == fc_reg);
                ex_wrote = 1'b1;
                ex_widx  = abs_a;
                ex_wval  = {31'd0, cmp_r};
            end
            OP_CALL: begin
                ex_wrote = 1'b1;
                ex_widx  = fbase_reg;
                ex_wval  = 32'(pc_reg) + 32'd1;
                ex_pc    = PW'(fa_reg);
            end
            OP_RET:  ex_pc = (rdata == '0) ? '0 : rdata[PW-1:0];
            default: ;
        endcase
    end

    // Datapath and register updates.
    always_comb begin
        kind_next  = kind_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        fc_next    = fc_reg;
        x_next     = x_reg;
        pc_next    = pc_reg;
        fbase_next = fbase_reg;
        stop_next  = stop_reg;
        clr_next   = clr_reg;
        out_next   = out_reg;
        we         = 1'b0;
        waddr      = clr_reg[AW-1:0];
        wdata      = '0;
        raddr      = idx_b;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                clr_next = clr_reg + (AW+1)'(1);
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    kind_next = s_axis_tuser;
                    fa_next   = s_axis_tdata[9:0];
                    fb_next   = s_axis_tdata[41:10];
                    fc_next   = s_axis_tdata[73:42];
                end
            end
            ST_READ1: raddr = idx_b;
            ST_READ2: begin
                x_next = rdata;
                if (kind_reg == OP_JMF) raddr = abs_a;
                else if (kind_reg == OP_RET) raddr = fbase_reg;
                else if (kind_reg == OP_COPY) raddr = idx_b;
                else raddr = idx_c;
            end
            ST_EXEC: begin
                if (kind_reg == OP_COPY) x_next = rdata;
                if (stop_reg) begin
                    out_next = {7'd0, 1'b0, 6'(fbase_reg), 32'd0, 6'd0, 1'b0,
                                1'b1, 10'(pc_reg)};
                end else begin
                    div_start = (kind_reg == OP_DIV) && (rdata != '0);
                    we    = ex_wrote && !div_start;
                    waddr = ex_widx;
                    wdata = (kind_reg == OP_COPY) ? x_reg : ex_wval;
                    pc_next = ex_pc;
                    if (kind_reg == OP_LT || kind_reg == OP_GT || kind_reg == OP_EQ)
                        fbase_next = abs_a;
                    else if (kind_reg == OP_POP)
                        fbase_next = fbase_reg - fa_reg[AW-1:0];
                    else if (kind_reg == OP_PUSH)
                        fbase_next = fbase_reg + fa_reg[AW-1:0];
                    if (kind_reg == OP_HALT || (kind_reg == OP_RET && rdata == '0))
                        stop_next = 1'b1;
                    out_next = {7'd0, ex_derr, 6'(fbase_next), ex_wval, 6'(ex_widx),
                                ex_wrote, stop_next, 10'(ex_pc)};
                    if (!ex_wrote) out_next[49:12] = '0;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    we    = 1'b1;
                    waddr = idx_a;
                    wdata = div_q;
                    out_next[49:18] = div_q;
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        fa_reg   <= fa_next;
        fb_reg   <= fb_next;
        fc_reg   <= fc_next;
        x_reg    <= x_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pc_reg    <= '0;
            fbase_reg <= '0;
            stop_reg  <= 1'b0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            fbase_reg <= fbase_next;
            stop_reg  <= stop_next;
            clr_reg   <= clr_next;
        end
    end

    logic unused_busy;
    assign unused_busy = div_stat.busy & div_stat.start;
endmodule
`default_nettype wire

### rtl/core/sfvm_checker.sv
// Port-level checker for the execute unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sfvm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);
    `CHK_IMPLY(a_one_side, aclk, aresetn, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CHK_NEXT(a_no_early, aclk, aresetn, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
    `CHK_IMPLY(a_nowrite_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[11],
        m_axis_tdata[49:12] == 38'd0)
endmodule

bind stack_frame_vm_execute_unit sfvm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### bench/stack_frame_vm_execute_unit_checker.sv
// Checker that predicts and compares every result beat of the execute unit.
`timescale 1ns / 1ps
module stack_frame_vm_execute_unit_checker
    import sfvm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic [4:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    output int               fail_count,
    output int               pending_count
);
    // Fields from the highest bit down, as packed in m_axis_tdata.
    typedef struct packed {
        logic        div_error;
        logic [5:0]  frame_base_out;
        logic [31:0] write_value;
        logic [5:0]  write_index;
        logic        wrote;
        logic        halted;
        logic [9:0]  next_pc;
    } exec_result_t;

    logic [31:0]  reg_mirror [64];
    logic [9:0]   pc_mirror;
    logic [5:0]   frame_mirror;
    logic         stop_mirror;
    exec_result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic exec_result_t execute_instruction(logic [4:0] kind, logic [9:0] fa,
                                                         logic [31:0] fb, logic [31:0] fc);
        exec_result_t r;
        logic [31:0] x;
        logic [31:0] y;
        r = '0;
        r.next_pc = pc_mirror + 10'd1;
        if (stop_mirror) begin
            r.next_pc = pc_mirror;
        end else begin
            // Indices wrap modulo a power of two, so the low bits of the sum suffice.
            x = reg_mirror[frame_mirror + fb[5:0]];
            y = reg_mirror[frame_mirror + fc[5:0]];
            case (kind)
                OP_ADD, OP_MUL, OP_SUB, OP_DIV: begin
                    r.wrote = 1'b1;
                    r.write_index = frame_mirror + fa[5:0];
                    if (kind == OP_ADD) r.write_value = x + y;
                    else if (kind == OP_MUL) r.write_value = x * y;
                    else if (kind == OP_SUB) r.write_value = x - y;
                    else if (y == '0) r.div_error = 1'b1;
                    else if (x == 32'h8000_0000 && y == '1) r.write_value = x;
                    else r.write_value = $signed(x) / $signed(y);
                end
                OP_COPY: begin
                    r.wrote = 1'b1;
                    r.write_index = frame_mirror + fa[5:0];
                    r.write_value = x;
                end
                OP_LOAD: begin
                    r.wrote = 1'b1;
                    r.write_index = frame_mirror + fa[5:0];
                    r.write_value = fb;
                end
                OP_JMP: r.next_pc = fa;
                OP_JMF: if (reg_mirror[fa[5:0]] == '0) r.next_pc = fb[9:0];
                OP_LT, OP_GT, OP_EQ: begin
                    r.wrote = 1'b1;
                    r.write_index = fa[5:0];
                    if (kind == OP_LT) r.write_value = {31'd0, $signed(fb) < $signed(fc)};
                    else if (kind == OP_GT) r.write_value = {31'd0, $signed(fb) > $signed(fc)};
                    else r.write_value = {31'd0, fb == fc};
                    frame_mirror = fa[5:0];
                end
                OP_CALL: begin
                    // The return address is stored without wrapping at the program depth.
                    r.wrote = 1'b1;
                    r.write_index = frame_mirror;
                    r.write_value = {22'd0, pc_mirror} + 32'd1;
                    r.next_pc = fa;
                end
                OP_RET: begin
                    if (reg_mirror[frame_mirror] == '0) begin
                        stop_mirror = 1'b1;
                        r.next_pc = '0;
                    end else begin
                        r.next_pc = reg_mirror[frame_mirror][9:0];
                    end
                end
                OP_HALT: stop_mirror = 1'b1;
                OP_POP:  frame_mirror = frame_mirror - fa[5:0];
                OP_PUSH: frame_mirror = frame_mirror + fa[5:0];
                default: ;
            endcase
            if (r.wrote) reg_mirror[r.write_index] = r.write_value;
            pc_mirror = r.next_pc;
        end
        r.halted = stop_mirror;
        r.frame_base_out = frame_mirror;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        exec_result_t exp_r;
        exec_result_t act_r;
        if (!aresetn) begin
            foreach (reg_mirror[i]) reg_mirror[i] = '0;
            pc_mirror = '0;
            frame_mirror = '0;
            stop_mirror = 1'b0;
            expected_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(execute_instruction(s_axis_tuser,
                    s_axis_tdata[9:0], s_axis_tdata[41:10], s_axis_tdata[73:42]));
            if (m_axis_tvalid && m_axis_tready) begin
                act_r = exec_result_t'(m_axis_tdata[56:0]);
                if (expected_results.size() == 0) begin
                    $error("result beat with no instruction outstanding: 0x%0h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("next_pc", exp_r.next_pc, act_r.next_pc);
                    check_field("halted", exp_r.halted, act_r.halted);
                    check_field("wrote", exp_r.wrote, act_r.wrote);
                    check_field("write_index", exp_r.write_index, act_r.write_index);
                    check_field("write_value", exp_r.write_value, act_r.write_value);
                    check_field("frame_base_out", exp_r.frame_base_out, act_r.frame_base_out);
                    check_field("div_error", exp_r.div_error, act_r.div_error);
                end
            end
        end
    end
endmodule

### bench/tb_stack_frame_vm_execute_unit.sv
// Testbench top: drives instruction beats into the execute unit and gives the verdict.
`timescale 1ns / 1ps
module tb_stack_frame_vm_execute_unit;
    import sfvm_pkg::*;

    // Opcodes outside the defined set; the unit must treat them as plain fall-through.
    localparam logic [4:0] OP_NONE_LO = 5'd0;
    localparam logic [4:0] OP_NONE_HI = 5'd31;
    localparam int PHASE_ITEMS = 650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [4:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_request;
    int          cycle_count;

    stack_frame_vm_execute_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    stack_frame_vm_execute_unit_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // A run that wedges anywhere ends here.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls at the falling edge, plus one long hold-off on request
    // so that the result register stays full and the unit stops taking beats.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // One instruction beat. Called at a falling edge, returns at a falling edge.
    // tvalid stays high between back-to-back beats without being dropped.
    task automatic send_instruction(logic [4:0] kind, logic [9:0] fa,
                                    logic [31:0] fb, logic [31:0] fc);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 80'({$urandom, $urandom, $urandom});
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {6'd0, fc, fb, fa};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Operand values lean toward small numbers and the extremes so that
    // divides, compares and jump-if-zero hit their interesting cases often.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h8000_0000;
            2: return '1;
            3: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed random instruction traffic. Halt is left out and return
    // only follows a call, so that execution never stops before the final tail.
    task automatic send_random_instruction(output int beats);
        logic [4:0] kind;
        logic [9:0] fa;
        beats = 1;
        fa = 10'($urandom);
        case ($urandom_range(0, 19))
            0, 1, 2:  send_instruction(OP_LOAD, fa, pick_value(), $urandom);
            3:        send_instruction(OP_ADD, fa, $urandom, $urandom);
            4:        send_instruction(OP_MUL, fa, $urandom, $urandom);
            5:        send_instruction(OP_SUB, fa, $urandom, $urandom);
            6, 7:     send_instruction(OP_DIV, fa, $urandom, $urandom);
            8:        send_instruction(OP_COPY, fa, $urandom, $urandom);
            9:        send_instruction(OP_JMP, fa, $urandom, $urandom);
            10, 11:   send_instruction(OP_JMF, fa, $urandom, $urandom);
            12:       send_instruction(OP_LT, fa, pick_value(), pick_value());
            13:       send_instruction(OP_GT, fa, pick_value(), pick_value());
            14:       send_instruction(OP_EQ, fa, pick_value(), pick_value());
            15: begin
                send_instruction(OP_CALL, fa, $urandom, $urandom);
                send_instruction(OP_RET, 10'($urandom), $urandom, $urandom);
                beats = 2;
            end
            16:       send_instruction(OP_POP, fa, $urandom, $urandom);
            17:       send_instruction(OP_PUSH, fa, $urandom, $urandom);
            default: begin
                kind = ($urandom_range(0, 1) == 0) ? OP_NONE_LO
                                                   : 5'($urandom_range(17, 31));
                send_instruction(kind, fa, $urandom, $urandom);
            end
        endcase
    endtask

    task automatic run_random_phase(int tx_pct, int rx_pct);
        int sent;
        int beats;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            send_random_instruction(beats);
            sent += beats;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NONE_LO;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_request  = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, starting from a frame base of zero: seed extreme operands,
        // then every opcode but halt, overflowing and zero divides, wrapped offsets.
        send_instruction(OP_LOAD, 10'd1, 32'h8000_0000, '0);
        send_instruction(OP_LOAD, 10'd2, '1, '0);
        send_instruction(OP_LOAD, 10'd3, 32'd7, '1);
        send_instruction(OP_LOAD, 10'd4, 32'h7fff_ffff, '0);
        send_instruction(OP_ADD, 10'd5, 32'd3, 32'd4);
        send_instruction(OP_MUL, 10'd6, 32'd4, 32'd4);
        send_instruction(OP_SUB, 10'd7, 32'd1, 32'd4);
        send_instruction(OP_DIV, 10'd8, 32'd1, 32'd2);
        send_instruction(OP_DIV, 10'd9, 32'd3, 32'd0);
        send_instruction(OP_DIV, 10'd10, 32'd1, 32'd3);
        send_instruction(OP_DIV, 10'd11, -32'sd61, -32'sd62);
        send_instruction(OP_COPY, 10'd1023, '1, 32'h8000_0000);
        send_instruction(OP_JMP, 10'd1023, '0, '0);
        send_instruction(OP_JMF, 10'd0, '1, '0);
        send_instruction(OP_JMF, 10'd1, 32'd5, '0);
        send_instruction(OP_LT, 10'd1023, 32'h8000_0000, 32'h7fff_ffff);
        send_instruction(OP_GT, 10'd12, 32'h7fff_ffff, 32'h8000_0000);
        send_instruction(OP_EQ, 10'd0, '1, '1);
        send_instruction(OP_PUSH, 10'd1023, '0, '0);
        send_instruction(OP_POP, 10'd5, '0, '0);
        send_instruction(OP_CALL, 10'd512, '0, '0);
        send_instruction(OP_RET, 10'd0, '0, '0);
        send_instruction(OP_NONE_LO, 10'd1023, '1, '1);
        send_instruction(OP_NONE_HI, 10'd0, '0, '0);

        run_random_phase(30, 87);
        run_random_phase(87, 30);
        // Long receiver hold-off while the sender keeps beats coming.
        hold_request = 1'b1;
        run_random_phase(0, 0);

        // Stop tail: clear the frame slot, return through it to halt, then
        // check that halt and everything after it are ignored.
        send_instruction(OP_LOAD, 10'd0, '0, '0);
        send_instruction(OP_RET, 10'd0, '0, '0);
        send_instruction(OP_HALT, 10'd0, '0, '0);
        send_instruction(OP_LOAD, 10'd3, '1, '0);
        send_instruction(OP_JMP, 10'd7, '0, '0);
        s_axis_tvalid = 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/sfvm_pkg.sv
rtl/core/sfvm_divider.sv
rtl/core/sfvm_regfile.sv
rtl/core/stack_frame_vm_execute_unit.sv
rtl/core/sfvm_checker.sv
bench/stack_frame_vm_execute_unit_checker.sv
bench/tb_stack_frame_vm_execute_unit.sv
